### hdl/bsr_pressure_residual_reduce_macros.svh
// assertion macros for the reduced pressure residual block
// used by bprr_merge, which checks its own logic; no other dependencies
`ifndef BSR_PRESSURE_RESIDUAL_REDUCE_MACROS_SVH
`define BSR_PRESSURE_RESIDUAL_REDUCE_MACROS_SVH

// property holds at every clock edge outside reset
`define BPRR_ASSERT(lbl, clk, rst, pexpr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) pexpr) else $error(msg);

// condition never true outside reset
`define BPRR_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hdl/bprr_pkg.sv
// shared widths, request codes and control structs for the residual reduce block
// no dependencies
package bprr_pkg;

   localparam int VALUE_W   = 32;
   localparam int SUM_W     = 64;
   localparam int COL_W     = 12;
   localparam int ROW_W     = 12;
   localparam int CC_W      = 3;
   localparam int PORT_LANES = 6;
   localparam int PAIR_COUNT = PORT_LANES / 2;

   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_ENTRY  = 2'd1;
   localparam logic [1:0] REQ_FINISH = 2'd2;

   localparam logic [CC_W-1:0] CC_RESET = 3'd3;

   typedef struct packed {
      logic advance;
      logic write;
      logic mac_en;
   } lane_ctrl_type;

   typedef struct packed {
      logic                       valid;
      logic                       finish;
      logic signed [VALUE_W-1:0]  residual;
   } stage_ctrl_type;

endpackage

### hdl/bprr_ifs.sv
// valid/ready channel interfaces: request, response and csr write
// depends on bprr_pkg
interface bprr_req_if;
   import bprr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [1:0]                req_type;
   logic [COL_W-1:0]          block_column;
   logic signed [VALUE_W-1:0] row_residual;
   logic signed [VALUE_W-1:0] lane_value_1;
   logic signed [VALUE_W-1:0] lane_value_2;
   logic signed [VALUE_W-1:0] lane_value_3;
   logic signed [VALUE_W-1:0] lane_value_4;
   logic signed [VALUE_W-1:0] lane_value_5;
   logic signed [VALUE_W-1:0] lane_value_6;

   modport source (output valid, req_type, block_column, row_residual, lane_value_1,
                   lane_value_2, lane_value_3, lane_value_4, lane_value_5, lane_value_6,
                   input ready);
   modport sink (input valid, req_type, block_column, row_residual, lane_value_1,
                 lane_value_2, lane_value_3, lane_value_4, lane_value_5, lane_value_6,
                 output ready);
endinterface

interface bprr_rsp_if;
   import bprr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [ROW_W-1:0]          row_index;
   logic signed [VALUE_W-1:0] reduced_residual;
   logic                      saturated;

   modport source (output valid, row_index, reduced_residual, saturated, input ready);
   modport sink (input valid, row_index, reduced_residual, saturated, output ready);
endinterface

interface bprr_csr_if;
   import bprr_pkg::*;
   logic            valid;
   logic            ready;
   logic [CC_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

### hdl/bsr_pressure_residual_reduce.sv
// top level of the reduced pressure residual block: lanes, pipeline control, csr
// depends on bprr_pkg, bprr_ifs, bprr_lane and bprr_merge
//
//  channel | direction | transaction carries
//  req_bus | in        | req_type, block_column, row_residual, lane_value_1..6
//  rsp_bus | out       | row_index, reduced_residual, saturated
//  csr_bus | in        | component_count write data
//
// one request per cycle while the pipeline is not held; a finish's response passes
// through store read, lane multiply, two tree levels, accumulate and round, clamp
// synchronous reset clears pipeline valids, the row sum, the row counter and
// component_count to 3; the solution store is not cleared and is ready at once
// the whole pipeline holds while a response waits and rsp_bus.ready is low
// csr writes are always taken: csr_bus.ready is tied high
module bsr_pressure_residual_reduce #(
   parameter int MAX_BLOCKS     = 4096,
   parameter int MAX_COMPONENTS = 7
) (
   input logic       clock,
   input logic       reset,
   bprr_req_if.sink  req_bus,
   bprr_rsp_if.source rsp_bus,
   bprr_csr_if.sink  csr_bus
);
   import bprr_pkg::*;

   localparam int LANES       = MAX_COMPONENTS - 1;
   localparam int COL_SPAN    = 1 << COL_W;
   localparam int STORE_DEPTH = (MAX_BLOCKS < COL_SPAN) ? MAX_BLOCKS : COL_SPAN;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [16:0] BLOCK_LIMIT = 17'(MAX_BLOCKS);

   logic                      advance;
   logic                      accept;
   logic                      in_range;
   logic [ADDR_W-1:0]         addr;
   logic [CC_W-1:0]           cc_ff;
   logic signed [VALUE_W-1:0] lane_in [PORT_LANES];
   logic signed [SUM_W-1:0]   product [LANES];
   stage_ctrl_type            ctrl_s0;
   stage_ctrl_type            ctrl_s1_ff;
   stage_ctrl_type            ctrl_s2_ff;

   assign req_bus.ready = advance;
   assign accept        = req_bus.valid && advance;
   assign in_range      = {5'd0, req_bus.block_column} < BLOCK_LIMIT;
   assign addr          = ADDR_W'(req_bus.block_column);

   assign lane_in[0] = req_bus.lane_value_1;
   assign lane_in[1] = req_bus.lane_value_2;
   assign lane_in[2] = req_bus.lane_value_3;
   assign lane_in[3] = req_bus.lane_value_4;
   assign lane_in[4] = req_bus.lane_value_5;
   assign lane_in[5] = req_bus.lane_value_6;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= CC_RESET;
      end else if (csr_bus.valid) begin
         cc_ff <= csr_bus.data;
      end
   end

   genvar k;
   generate
      for (k = 0; k < LANES; k++) begin : g_lane
         lane_ctrl_type lane_ctrl;

         assign lane_ctrl.advance = advance;
         assign lane_ctrl.write   = accept && in_range && (req_bus.req_type == REQ_LOAD);
         assign lane_ctrl.mac_en  = accept && in_range && (req_bus.req_type == REQ_ENTRY)
                                    && (CC_W'(k + 1) < cc_ff);

         bprr_lane #(
            .DEPTH  (STORE_DEPTH),
            .ADDR_W (ADDR_W)
         ) u_lane (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (lane_ctrl),
            .addr       (addr),
            .wdata      (lane_in[k]),
            .coef       (lane_in[k]),
            .product_ff (product[k])
         );
      end
   endgenerate

   assign ctrl_s0.valid    = accept;
   assign ctrl_s0.finish   = req_bus.req_type == REQ_FINISH;
   assign ctrl_s0.residual = req_bus.row_residual;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_s1_ff <= '0;
         ctrl_s2_ff <= '0;
      end else if (advance) begin
         ctrl_s1_ff <= ctrl_s0;
         ctrl_s2_ff <= ctrl_s1_ff;
      end
   end

   bprr_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock   (clock),
      .reset   (reset),
      .ctrl_s2 (ctrl_s2_ff),
      .product (product),
      .advance (advance),
      .rsp     (rsp_bus)
   );

endmodule

### hdl/bprr_lane.sv
// one lane: solution component store and its coefficient multiplier
// depends on bprr_pkg
module bprr_lane #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bprr_pkg::lane_ctrl_type            ctrl,
   input  logic [ADDR_W-1:0]                  addr,
   input  logic signed [bprr_pkg::VALUE_W-1:0] wdata,
   input  logic signed [bprr_pkg::VALUE_W-1:0] coef,
   output logic signed [bprr_pkg::SUM_W-1:0]   product_ff
);
   import bprr_pkg::*;

   logic [VALUE_W-1:0]        mem [DEPTH];
   logic signed [VALUE_W-1:0] rdata_ff;
   logic signed [VALUE_W-1:0] coef_ff;
   logic                      mac_en_ff;
   logic signed [SUM_W-1:0]   mult;
   logic signed [SUM_W-1:0]   product_in;

   always_ff @(posedge clock) begin
      if (ctrl.advance && ctrl.write) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         rdata_ff <= $signed(mem[addr]);
         coef_ff  <= coef;
      end
   end

   assign mult       = coef_ff * rdata_ff;
   assign product_in = mac_en_ff ? mult : 64'sd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_en_ff  <= 1'b0;
         product_ff <= '0;
      end else if (ctrl.advance) begin
         mac_en_ff  <= ctrl.mac_en;
         product_ff <= product_in;
      end
   end

endmodule

### hdl/bprr_merge.sv
// merge stage: lane product tree, row accumulator, rounding and saturation
// depends on bprr_pkg, bprr_ifs and the assertion macro header
`include "bsr_pressure_residual_reduce_macros.svh"

module bprr_merge #(
   parameter int LANES = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bprr_pkg::stage_ctrl_type          ctrl_s2,
   input  logic signed [bprr_pkg::SUM_W-1:0] product [LANES],
   output logic                              advance,
   bprr_rsp_if.source                        rsp
);
   import bprr_pkg::*;

   localparam logic signed [VALUE_W-1:0] SAT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] SAT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam int RND_W  = SUM_W - 16 + 1;
   localparam int DIFF_W = RND_W + 1;

   logic signed [SUM_W-1:0]  padded [PORT_LANES];
   logic signed [SUM_W-1:0]  pair_ff [PAIR_COUNT];
   logic signed [SUM_W-1:0]  total_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [RND_W-1:0]  rounded_ff;
   logic signed [RND_W-1:0]  rounded_in;
   logic signed [VALUE_W-1:0] resid5_ff;
   logic                     fin5_ff;
   stage_ctrl_type           ctrl3_ff;
   stage_ctrl_type           ctrl4_ff;
   logic signed [DIFF_W-1:0] diff;
   logic signed [VALUE_W-1:0] result_in;
   logic                     sat_in;
   logic                     out_valid_ff;
   logic [ROW_W-1:0]         row_ff;
   logic [ROW_W-1:0]         row_out_ff;
   logic signed [VALUE_W-1:0] result_ff;
   logic                     sat_ff;

   assign advance = !out_valid_ff || rsp.ready;

   genvar k;
   generate
      for (k = 0; k < PORT_LANES; k++) begin : g_pad
         if (k < LANES) begin : g_used
            assign padded[k] = product[k];
         end else begin : g_zero
            assign padded[k] = '0;
         end
      end
   endgenerate

   // tree: pairs, then total
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < PAIR_COUNT; j++) begin
            pair_ff[j] <= '0;
         end
         total_ff <= '0;
      end else if (advance) begin
         for (int j = 0; j < PAIR_COUNT; j++) begin
            pair_ff[j] <= padded[2*j] + padded[2*j+1];
         end
         total_ff <= pair_ff[0] + pair_ff[1] + pair_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl3_ff <= '0;
         ctrl4_ff <= '0;
      end else if (advance) begin
         ctrl3_ff <= ctrl_s2;
         ctrl4_ff <= ctrl3_ff;
      end
   end

   // round to nearest, ties up
   assign rounded_in = RND_W'($signed(sum_ff[SUM_W-1:16])) + RND_W'({1'b0, sum_ff[15]});

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         fin5_ff <= 1'b0;
      end else if (advance) begin
         if (ctrl4_ff.valid && ctrl4_ff.finish) begin
            sum_ff  <= '0;
            fin5_ff <= 1'b1;
         end else begin
            sum_ff  <= sum_ff + total_ff;
            fin5_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rounded_ff <= rounded_in;
         resid5_ff  <= ctrl4_ff.residual;
      end
   end

   assign diff = DIFF_W'(resid5_ff) - DIFF_W'(rounded_ff);

   always_comb begin
      if (diff > DIFF_W'(SAT_MAX)) begin
         result_in = SAT_MAX;
         sat_in    = 1'b1;
      end else if (diff < DIFF_W'(SAT_MIN)) begin
         result_in = SAT_MIN;
         sat_in    = 1'b1;
      end else begin
         result_in = diff[VALUE_W-1:0];
         sat_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         row_ff       <= '0;
      end else if (advance) begin
         out_valid_ff <= fin5_ff;
         if (fin5_ff) begin
            row_ff <= row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && fin5_ff) begin
         row_out_ff <= row_ff;
         result_ff  <= result_in;
         sat_ff     <= sat_in;
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.row_index        = row_out_ff;
   assign rsp.reduced_residual = result_ff;
   assign rsp.saturated        = sat_ff;

   `BPRR_ASSERT(a_row_step, clock, reset,
      (advance && fin5_ff) |=> (row_ff == $past(row_ff) + 1'b1),
      "row counter did not step on finish")
   `BPRR_ASSERT(a_sum_hold, clock, reset, !advance |=> $stable(sum_ff),
      "row sum moved during stall")
   `BPRR_ASSERT(a_sum_clear, clock, reset,
      (advance && ctrl4_ff.valid && ctrl4_ff.finish) |=> (sum_ff == '0),
      "row sum not cleared after finish")
   `BPRR_ASSERT(a_sat_value, clock, reset,
      (out_valid_ff && sat_ff) |-> (result_ff == SAT_MAX || result_ff == SAT_MIN),
      "saturated result not at a limit")

endmodule
